// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// types and constants of the go-back-n sender window
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int SEQ_BITS       = 16;
   localparam int MAX_WINDOW_DEF = 8;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 1;

   // request opcodes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_ACK   = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_RESEND = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 1'd1;

   localparam logic [3:0]  WINDOW_SIZE_RESET   = 4'd5;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] frame_total;
      logic [15:0] ack_num;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] seq_num;
      logic        last;
   } rsp_payload_type;

endpackage

// ----- design/gbn_if.sv -----
// ----------------------------------------------------------------------------
// gbn_req_if / gbn_rsp_if
// valid/ready channels for requests and results of the sender window
// ----------------------------------------------------------------------------
interface gbn_req_if;
   import gbn_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface gbn_rsp_if;
   import gbn_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/go_back_n_sender_window_core.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// go-back-n arq sender window: start, cumulative ack and tick requests in,
// send / resend / done commands out
// ----------------------------------------------------------------------------
//
// channel   dir   handshake      payload
// req       in    valid/ready    opcode, frame_total, ack_num
// rsp       out   valid/ready    kind, seq_num, last
// csr       in    write enable   csr_index, csr_write_data
//
// a request is decoded while the sequencer is idle; the shared sequence
// incrementer/comparator then issues its send or resend commands in turn,
// up to MAX_WINDOW of them; a request that opens no slot issues none, and
// a request that is dropped or a tick that does not time out stays in idle
// req.ready is high only while the sequencer is idle; one result register
// sits on rsp: a stall on rsp holds the sequencer, but once the last command
// of a request is in that register the next request can be taken
// synchronous active-high reset; no clearing pass is needed
//
module go_back_n_sender_window_core #(
   parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   gbn_req_if.sink                            req,
   gbn_rsp_if.source                          rsp,
   input  logic                               csr_write_enable,
   input  logic [gbn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import gbn_pkg::*;

   // window clamp and resend counter widths
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int EW    = (CNT_W > 4) ? CNT_W : 4;
   localparam int LW    = SEQ_BITS + 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FILL   = 2'd1;
   localparam logic [1:0] ST_RESEND = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]          state_ff,  state_in;
   logic [3:0]          wsize_ff,  wsize_in;
   logic [15:0]         tmo_ff,    tmo_in;
   logic [SEQ_BITS-1:0] base_ff,   base_in;
   logic [SEQ_BITS-1:0] next_ff,   next_in;
   logic [SEQ_BITS-1:0] total_ff,  total_in;
   logic [15:0]         timer_ff,  timer_in;
   logic                active_ff, active_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // working registers of the sequencer, no reset needed
   logic [LW-1:0]       limit_ff,  limit_in;
   logic [SEQ_BITS-1:0] rs_seq_ff, rs_seq_in;
   logic [CNT_W-1:0]    rs_cnt_ff, rs_cnt_in;
   rsp_payload_type     rsp_pl_ff, rsp_pl_in;

   logic                req_fire;
   logic                out_free;
   logic [EW-1:0]       eff_win;
   logic [15:0]         tmo_eff;
   logic [15:0]         timer_inc;
   logic [SEQ_BITS-1:0] ack_plus;
   logic                ack_in_window;
   // shared unit: one incremented sequence and its compares
   logic [SEQ_BITS-1:0] cur_seq;
   logic [LW-1:0]       cur_plus;
   logic                cur_ok;
   logic                plus_ok;
   logic [CNT_W:0]      cnt_plus;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_pl_ff;

   // window size: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (wsize_ff == 4'd0) begin
         eff_win = EW'(1);
      end else if (EW'(wsize_ff) > EW'(MAX_WINDOW)) begin
         eff_win = EW'(MAX_WINDOW);
      end else begin
         eff_win = EW'(wsize_ff);
      end
   end

   assign tmo_eff       = (tmo_ff == 16'd0) ? 16'd1 : tmo_ff;
   assign timer_inc     = timer_ff + 16'd1;
   assign ack_plus      = req.payload.ack_num + SEQ_BITS'(1);
   assign ack_in_window = (req.payload.ack_num >= base_ff) &&
                          (req.payload.ack_num < next_ff);

   // the cursor is the resend pointer while resending, next_sequence otherwise
   assign cur_seq  = (state_ff == ST_RESEND) ? rs_seq_ff : next_ff;
   assign cur_plus = {1'b0, cur_seq} + LW'(1);
   assign cnt_plus = {1'b0, rs_cnt_ff} + (CNT_W + 1)'(1);

   always_comb begin
      if (state_ff == ST_RESEND) begin
         cur_ok  = (cur_seq < next_ff) && ({1'b0, rs_cnt_ff} < (CNT_W + 1)'(MAX_WINDOW));
         plus_ok = (cur_plus < {1'b0, next_ff}) && (cnt_plus < (CNT_W + 1)'(MAX_WINDOW));
      end else begin
         cur_ok  = ({1'b0, cur_seq} < limit_ff) && (cur_seq < total_ff);
         plus_ok = (cur_plus < limit_ff) && (cur_plus < {1'b0, total_ff});
      end
   end

   // configuration writes
   always_comb begin
      wsize_in = wsize_ff;
      tmo_in   = tmo_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_SIZE:   wsize_in = csr_write_data[3:0];
            CSR_TIMEOUT_TICKS: tmo_in   = csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      total_in     = total_ff;
      timer_in     = timer_ff;
      active_in    = active_ff;
      limit_in     = limit_ff;
      rs_seq_in    = rs_seq_ff;
      rs_cnt_in    = rs_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pl_in    = rsp_pl_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.payload.opcode)
                  OP_START: begin
                     if (!active_ff) begin
                        total_in = req.payload.frame_total;
                        base_in  = '0;
                        next_in  = '0;
                        timer_in = '0;
                        limit_in = LW'(eff_win);
                        if (req.payload.frame_total == '0) begin
                           state_in = ST_DONE;
                        end else begin
                           active_in = 1'b1;
                           state_in  = ST_FILL;
                        end
                     end
                  end
                  OP_ACK: begin
                     if (active_ff && ack_in_window) begin
                        base_in  = ack_plus;
                        timer_in = '0;
                        limit_in = {1'b0, ack_plus} + LW'(eff_win);
                        if (ack_plus >= total_ff) begin
                           active_in = 1'b0;
                           state_in  = ST_DONE;
                        end else begin
                           state_in  = ST_FILL;
                        end
                     end
                  end
                  OP_TICK: begin
                     if (active_ff) begin
                        if (timer_inc >= tmo_eff) begin
                           timer_in  = '0;
                           rs_seq_in = base_ff;
                           rs_cnt_in = '0;
                           state_in  = ST_RESEND;
                        end else begin
                           timer_in  = timer_inc;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL, ST_RESEND: begin
            if (!cur_ok) begin
               // nothing to issue
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_pl_in.kind    = (state_ff == ST_FILL) ? KIND_SEND : KIND_RESEND;
               rsp_pl_in.seq_num = cur_seq;
               rsp_pl_in.last    = !plus_ok;
               if (state_ff == ST_FILL) begin
                  next_in = cur_plus[SEQ_BITS-1:0];
               end else begin
                  rs_seq_in = cur_plus[SEQ_BITS-1:0];
                  rs_cnt_in = cnt_plus[CNT_W-1:0];
               end
               if (!plus_ok) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_pl_in.kind    = KIND_DONE;
               rsp_pl_in.seq_num = '0;
               rsp_pl_in.last    = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wsize_ff     <= WINDOW_SIZE_RESET;
         tmo_ff       <= TIMEOUT_TICKS_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         total_ff     <= '0;
         timer_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsize_ff     <= wsize_in;
         tmo_ff       <= tmo_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         total_ff     <= total_in;
         timer_ff     <= timer_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff  <= limit_in;
      rs_seq_ff <= rs_seq_in;
      rs_cnt_ff <= rs_cnt_in;
      rsp_pl_ff <= rsp_pl_in;
   end

endmodule

// ----- design/gbn_checker.sv -----
// ----------------------------------------------------------------------------
// gbn_checker
// port-level checks of the sender window, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_seq_num,
   input logic        rsp_last
);
   import gbn_pkg::*;

   logic        stall;
   logic [19:0] rsp_word;
   logic        is_done;
   logic        done_ok;
   logic        mid_burst;

   assign stall     = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_valid, rsp_kind, rsp_seq_num, rsp_last};
   assign is_done   = rsp_valid && (rsp_kind == KIND_DONE);
   assign done_ok   = (rsp_seq_num == 16'd0) && rsp_last;
   assign mid_burst = rsp_valid && !rsp_last;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, stall, $stable(rsp_word), "result changed while stalled")
   `ASSERT_ALWAYS_NEXT(a_rsp_reset, clock, reset, !rsp_valid, "result valid after reset")
   `ASSERT_IMPLIES(a_done_form, clock, reset, is_done, done_ok, "done result malformed")
   `ASSERT_IMPLIES(a_busy_burst, clock, reset, mid_burst, !req_ready, "request taken mid burst")

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_kind    (rsp.payload.kind),
   .rsp_seq_num (rsp.payload.seq_num),
   .rsp_last    (rsp.payload.last)
);
